>>> rtl/bmhq_pkg.sv
// Shared constants, types and command codes of the binary min-heap queue.
package bmhq_pkg;

	localparam int HEAP_DEPTH  = 1024;
	localparam int KEY_BITS    = 16;
	localparam int TAG_BITS    = 10;
	localparam int ADDR_BITS   = $clog2(HEAP_DEPTH);
	localparam int CNT_BITS    = $clog2(HEAP_DEPTH + 1);
	localparam int POS_BITS    = CNT_BITS + 1;
	localparam int ENTRY_BITS  = KEY_BITS + TAG_BITS;
	localparam int MODE_BITS   = 2;
	localparam int STAT_BITS   = 2;
	localparam int S_DATA_BITS = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;
	localparam int M_DATA_BITS = ((KEY_BITS + TAG_BITS + CNT_BITS + 1 + 7) / 8) * 8;

	typedef logic [MODE_BITS-1:0] mode_t;
	typedef logic [STAT_BITS-1:0] stat_t;
	typedef logic [3:0]           op_t;

	localparam mode_t MODE_INSERT = 2'd0;
	localparam mode_t MODE_REMOVE = 2'd1;
	localparam mode_t MODE_CLEAR  = 2'd2;

	localparam stat_t STAT_OK    = 2'd0;
	localparam stat_t STAT_EMPTY = 2'd1;
	localparam stat_t STAT_FULL  = 2'd2;

	// datapath operations issued by the controller, one per cycle
	localparam op_t OP_NONE      = 4'd0;
	localparam op_t OP_LATCH     = 4'd1;
	localparam op_t OP_INS_BEGIN = 4'd2;
	localparam op_t OP_RD_PARENT = 4'd3;
	localparam op_t OP_INS_MOVE  = 4'd4;
	localparam op_t OP_INS_PLACE = 4'd5;
	localparam op_t OP_RD_ENDS   = 4'd6;
	localparam op_t OP_REM_BEGIN = 4'd7;
	localparam op_t OP_RD_KIDS   = 4'd8;
	localparam op_t OP_REM_MOVE  = 4'd9;
	localparam op_t OP_REM_PLACE = 4'd10;
	localparam op_t OP_CLEAR     = 4'd11;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
	} entry_t;

	typedef struct packed {
		op_t   op;
		logic  res_load;
		stat_t res_status;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  full;
		logic  empty;
		logic  at_root;
		logic  key_lt_parent;
		logic  child_in;
		logic  moved_gt_child;
		logic  out_free;
	} dp_stat_t;

endpackage

>>> rtl/bmhq_ctrl.sv
// Request sequencer of the heap queue: walks insert, remove and clear through the datapath.
module bmhq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  bmhq_pkg::dp_stat_t st,
	output bmhq_pkg::cmd_t    cmd
);
	import bmhq_pkg::*;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_DECODE    = 4'd1;
	localparam logic [3:0] ST_INS_CHK   = 4'd2;
	localparam logic [3:0] ST_INS_CMP   = 4'd3;
	localparam logic [3:0] ST_REM_BEGIN = 4'd4;
	localparam logic [3:0] ST_REM_CHK   = 4'd5;
	localparam logic [3:0] ST_REM_CMP   = 4'd6;
	localparam logic [3:0] ST_DONE      = 4'd7;

	logic [3:0] state_q, state_d;
	stat_t      res_q, res_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d        = state_q;
		res_d          = res_q;
		cmd.op         = OP_NONE;
		cmd.res_load   = 1'b0;
		cmd.res_status = res_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LATCH;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				res_d   = STAT_OK;
				state_d = ST_DONE;
				unique case (st.mode)
					MODE_INSERT: begin
						if (st.full) begin
							res_d = STAT_FULL;
						end else begin
							cmd.op  = OP_INS_BEGIN;
							state_d = ST_INS_CHK;
						end
					end
					MODE_REMOVE: begin
						if (st.empty) begin
							res_d = STAT_EMPTY;
						end else begin
							cmd.op  = OP_RD_ENDS;
							state_d = ST_REM_BEGIN;
						end
					end
					MODE_CLEAR: cmd.op = OP_CLEAR;
					default: ;
				endcase
			end
			ST_INS_CHK: begin
				if (st.at_root) begin
					cmd.op  = OP_INS_PLACE;
					state_d = ST_DONE;
				end else begin
					cmd.op  = OP_RD_PARENT;
					state_d = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				if (st.key_lt_parent) begin
					cmd.op  = OP_INS_MOVE;
					state_d = ST_INS_CHK;
				end else begin
					cmd.op  = OP_INS_PLACE;
					state_d = ST_DONE;
				end
			end
			ST_REM_BEGIN: begin
				cmd.op  = OP_REM_BEGIN;
				state_d = ST_REM_CHK;
			end
			ST_REM_CHK: begin
				if (st.child_in) begin
					cmd.op  = OP_RD_KIDS;
					state_d = ST_REM_CMP;
				end else begin
					cmd.op  = OP_REM_PLACE;
					state_d = ST_DONE;
				end
			end
			ST_REM_CMP: begin
				if (st.moved_gt_child) begin
					cmd.op  = OP_REM_MOVE;
					state_d = ST_REM_CHK;
				end else begin
					cmd.op  = OP_REM_PLACE;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the result register is free
				if (st.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_q   <= STAT_OK;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

>>> rtl/bmhq_dp.sv
// Heap datapath: entry memory, position counters, comparators and the result register.
module bmhq_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [bmhq_pkg::MODE_BITS-1:0]     in_mode,
	input  logic [bmhq_pkg::KEY_BITS-1:0]      in_key,
	input  logic [bmhq_pkg::TAG_BITS-1:0]      in_tag,
	input  bmhq_pkg::cmd_t                     cmd,
	output bmhq_pkg::dp_stat_t                 st,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [bmhq_pkg::M_DATA_BITS-1:0]   m_tdata,
	output logic [bmhq_pkg::STAT_BITS-1:0]     m_tuser
);
	import bmhq_pkg::*;

	logic [ENTRY_BITS-1:0] mem_q [HEAP_DEPTH];
	entry_t                rd_a_q, rd_b_q;
	logic [ADDR_BITS-1:0]  addr_a, addr_b, waddr;
	logic                  we;
	entry_t                wdata;

	mode_t                 mode_q;
	entry_t                new_q, ret_q, mov_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [POS_BITS-1:0]   pos_q, child_q;

	logic                  pick_right;
	entry_t                chosen;
	logic [POS_BITS-1:0]   chosen_pos, count_ext;

	logic                  out_valid_q;
	entry_t                out_ent_q;
	stat_t                 out_stat_q;
	logic [CNT_BITS-1:0]   out_count_q;
	logic                  out_empty_q;

	function automatic logic [ADDR_BITS-1:0] slot(input logic [POS_BITS-1:0] p);
		logic [POS_BITS-1:0] s;
		s = p - POS_BITS'(1);
		return s[ADDR_BITS-1:0];
	endfunction

	assign count_ext  = {1'b0, count_q};
	assign pick_right = (child_q < count_ext) && (rd_a_q.key > rd_b_q.key);
	assign chosen     = pick_right ? rd_b_q : rd_a_q;
	assign chosen_pos = pick_right ? child_q + POS_BITS'(1) : child_q;

	always_comb begin
		addr_a = '0;
		addr_b = '0;
		case (cmd.op)
			OP_RD_PARENT: addr_a = slot(pos_q >> 1);
			OP_RD_ENDS: begin
				addr_a = slot(POS_BITS'(1));
				addr_b = slot(count_ext);
			end
			OP_RD_KIDS: begin
				addr_a = slot(child_q);
				addr_b = slot(child_q + POS_BITS'(1));
			end
			default: ;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = slot(pos_q);
		wdata = new_q;
		case (cmd.op)
			OP_INS_MOVE: begin
				we    = 1'b1;
				wdata = rd_a_q;
			end
			OP_INS_PLACE: we = 1'b1;
			OP_REM_MOVE: begin
				we    = 1'b1;
				wdata = chosen;
			end
			OP_REM_PLACE: begin
				we    = 1'b1;
				wdata = mov_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_a_q <= mem_q[addr_a];
		rd_b_q <= mem_q[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.op)
				OP_INS_BEGIN: count_q <= count_q + CNT_BITS'(1);
				OP_REM_BEGIN: count_q <= count_q - CNT_BITS'(1);
				OP_CLEAR:     count_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				mode_q    <= in_mode;
				new_q.key <= in_key;
				new_q.tag <= in_tag;
				ret_q     <= '0;
			end
			OP_INS_BEGIN: pos_q <= count_ext + POS_BITS'(1);
			OP_INS_MOVE:  pos_q <= pos_q >> 1;
			OP_REM_BEGIN: begin
				ret_q   <= rd_a_q;
				mov_q   <= rd_b_q;
				pos_q   <= POS_BITS'(1);
				child_q <= POS_BITS'(2);
			end
			OP_REM_MOVE: begin
				pos_q   <= chosen_pos;
				child_q <= chosen_pos << 1;
			end
			default: ;
		endcase
	end

	// result register parts the request side from the result side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_ent_q   <= ret_q;
			out_stat_q  <= cmd.res_status;
			out_count_q <= count_q;
			out_empty_q <= (count_q == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_stat_q;
	assign m_tdata  = M_DATA_BITS'({out_empty_q, out_count_q, out_ent_q.tag, out_ent_q.key});

	assign st.mode           = mode_q;
	assign st.full           = (count_q == CNT_BITS'(HEAP_DEPTH));
	assign st.empty          = (count_q == '0);
	assign st.at_root        = (pos_q == POS_BITS'(1));
	assign st.key_lt_parent  = (new_q.key < rd_a_q.key);
	assign st.child_in       = (child_q <= count_ext);
	assign st.moved_gt_child = (mov_q.key > chosen.key);
	assign st.out_free       = !out_valid_q || m_tready;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(HEAP_DEPTH))
		else $error("entry count beyond heap depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || m_tready))
		else $error("result register overwritten before transfer");

	a_move_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_INS_MOVE) |-> (pos_q != POS_BITS'(1)))
		else $error("sift-up moved past the root");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_INS_BEGIN) |=> (count_q != '0))
		else $error("insert left the heap empty");

endmodule

>>> rtl/binary_min_heap_queue_top.sv
// Top level of the binary min-heap priority queue: stream ports, controller and datapath.
// One request at a time: s_tready is high only while the block is idle, and each request gives
// one result. A clear, an ignored code, removal from an empty heap or insertion into a full
// heap is answered straight from the decode; an insert climbs level by level until it reaches
// the root or stops below it, and a removal's moved entry sinks level by level until it has
// no child left or stops above that. The block is ready again in the same cycle as the result
// shows. An insert into 1023 entries climbs 10 levels, the most; a removal sinks at most 9.
// Each level takes a registered read of the entry memory, then the compare and write-back. A new
// request is taken while the previous result still waits in the output register; only the
// next result then waits for it. The entry memory needs no clearing after reset.
module binary_min_heap_queue_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// item_key [15:0], item_tag [25:16], zero pad
	input  logic [bmhq_pkg::S_DATA_BITS-1:0] s_tdata,
	// mode [1:0]
	input  logic [bmhq_pkg::MODE_BITS-1:0]   s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_key [15:0], out_tag [25:16], count [36:26], is_empty_flag [37], zero pad
	output logic [bmhq_pkg::M_DATA_BITS-1:0] m_tdata,
	// status [1:0]
	output logic [bmhq_pkg::STAT_BITS-1:0]   m_tuser
);
	import bmhq_pkg::*;

	cmd_t     cmd;
	dp_stat_t st;

	bmhq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	bmhq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_mode  (s_tuser),
		.in_key   (s_tdata[KEY_BITS-1:0]),
		.in_tag   (s_tdata[KEY_BITS+TAG_BITS-1:KEY_BITS]),
		.cmd      (cmd),
		.st       (st),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> tb/bmhq_checker.sv
// Checker for the binary min-heap queue: watches both streams, predicts each result and compares.
module bmhq_checker
	import bmhq_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [S_DATA_BITS-1:0] s_tdata,
	input  logic [MODE_BITS-1:0]   s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [M_DATA_BITS-1:0] m_tdata,
	input  logic [STAT_BITS-1:0]   m_tuser,
	output int                     mismatches,
	output int                     awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
		stat_t               status;
		logic [CNT_BITS-1:0] count;
		logic                empty;
	} heap_result_t;

	entry_t       heap_mem [1:HEAP_DEPTH];
	int unsigned  held_n;
	heap_result_t due_results [$];

	initial begin
		mismatches = 0;
		awaited    = 0;
		held_n     = 0;
	end

	// apply one request to the mirrored heap and work out the result it gives
	task automatic heap_step(input mode_t md, input logic [KEY_BITS-1:0] k,
	                         input logic [TAG_BITS-1:0] t, output heap_result_t r);
		int unsigned pos;
		int unsigned kid;
		entry_t      moved;
		logic        stop;
		r.key    = '0;
		r.tag    = '0;
		r.status = STAT_OK;
		case (md)
			MODE_INSERT: begin
				if (held_n >= HEAP_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					held_n++;
					pos = held_n;
					while (pos != 1 && k < heap_mem[pos / 2].key) begin
						heap_mem[pos] = heap_mem[pos / 2];
						pos = pos / 2;
					end
					heap_mem[pos].key = k;
					heap_mem[pos].tag = t;
				end
			end
			MODE_REMOVE: begin
				if (held_n == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.key = heap_mem[1].key;
					r.tag = heap_mem[1].tag;
					moved = heap_mem[held_n];
					held_n--;
					pos  = 1;
					kid  = 2;
					stop = 1'b0;
					// right child only when the left one is strictly greater; stop on ties
					while (!stop && kid <= held_n) begin
						if (kid < held_n && heap_mem[kid].key > heap_mem[kid + 1].key)
							kid++;
						if (moved.key <= heap_mem[kid].key) begin
							stop = 1'b1;
						end else begin
							heap_mem[pos] = heap_mem[kid];
							pos = kid;
							kid = kid * 2;
						end
					end
					heap_mem[pos] = moved;
				end
			end
			MODE_CLEAR: held_n = 0;
			default: ;
		endcase
		r.count = CNT_BITS'(held_n);
		r.empty = (held_n == 0);
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		heap_result_t want;
		heap_result_t fresh;
		if (!arst_n) begin
			held_n = 0;
			due_results.delete();
			awaited <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$error("result transfer with no request outstanding");
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("out_key", 32'(want.key), 32'(m_tdata[15:0]));
					check_field("out_tag", 32'(want.tag), 32'(m_tdata[25:16]));
					check_field("count", 32'(want.count), 32'(m_tdata[36:26]));
					check_field("is_empty_flag", 32'(want.empty), 32'(m_tdata[37]));
					check_field("status", 32'(want.status), 32'(m_tuser));
				end
			end
			if (s_tvalid && s_tready) begin
				heap_step(s_tuser, s_tdata[15:0], s_tdata[25:16], fresh);
				due_results.push_back(fresh);
			end
			awaited <= due_results.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// Testbench top for the binary min-heap queue: clock, reset, request stimulus and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bmhq_pkg::*;

	// request code the block ignores
	localparam mode_t MODE_IGNORED = 2'd3;

	logic                   clk      = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_DATA_BITS-1:0] s_tdata  = '0;
	logic [MODE_BITS-1:0]   s_tuser  = MODE_INSERT;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_DATA_BITS-1:0] m_tdata;
	logic [STAT_BITS-1:0]   m_tuser;

	int mismatches;
	int awaited;
	int n_sent = 0;
	int fill   = 0;

	always #5 clk = ~clk;

	binary_min_heap_queue_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	bmhq_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	task automatic send_req(input mode_t md, input logic [KEY_BITS-1:0] k,
	                        input logic [TAG_BITS-1:0] t);
		logic [S_DATA_BITS-1:0] word;
		word = '0;
		word[15:0]  = k;
		word[25:16] = t;
		// no gaps through the middle of the run
		if (n_sent < 600 || n_sent >= 900) begin
			while ($urandom_range(99) < 8) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= md;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		n_sent++;
		case (md)
			MODE_INSERT: if (fill < HEAP_DEPTH) fill++;
			MODE_REMOVE: if (fill > 0) fill--;
			MODE_CLEAR:  fill = 0;
			default: ;
		endcase
	endtask

	// hold the input until every outstanding result has been transferred
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (awaited != 0);
	endtask

	task automatic rand_req(input int ins_pct, input int clr_pct);
		int                  r;
		int                  pick;
		logic [KEY_BITS-1:0] k;
		r    = $urandom_range(99);
		pick = $urandom_range(3);
		// bias keys towards both ends so that ties are common
		if (pick == 0)
			k = KEY_BITS'($urandom_range(7));
		else if (pick == 1)
			k = KEY_BITS'($urandom_range(65535, 65528));
		else
			k = KEY_BITS'($urandom_range(65535));
		if (r < ins_pct)
			send_req(MODE_INSERT, k, TAG_BITS'($urandom_range(1023)));
		else if (r < ins_pct + clr_pct)
			send_req(MODE_CLEAR, k, TAG_BITS'($urandom_range(1023)));
		else if (r == 99)
			send_req(MODE_IGNORED, k, TAG_BITS'($urandom_range(1023)));
		else
			send_req(MODE_REMOVE, k, TAG_BITS'($urandom_range(1023)));
	endtask

	// result side: random stalls, one long hold-off and a stretch with none
	initial begin : rx_drive
		int seen;
		int hold;
		bit held;
		seen = 0;
		hold = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				seen++;
			if (!held && seen >= 300) begin
				held = 1'b1;
				hold = 500;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (seen >= 600 && seen < 900) || ($urandom_range(99) >= 8);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("binary_min_heap_queue_top test failed");
		$finish;
	end

	initial begin
		// falling edge from unknown starts the reset
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty removal, ignored code, extremes, ties, clear
		send_req(MODE_REMOVE, 16'hFFFF, 10'h3FF);
		send_req(MODE_IGNORED, 16'h0000, 10'h000);
		send_req(MODE_INSERT, 16'hFFFF, 10'h3FF);
		send_req(MODE_INSERT, 16'h0000, 10'h000);
		send_req(MODE_INSERT, 16'h8000, 10'h155);
		send_req(MODE_INSERT, 16'h8000, 10'h2AA);
		send_req(MODE_INSERT, 16'h0001, 10'h001);
		send_req(MODE_INSERT, 16'h0000, 10'h3FF);
		send_req(MODE_IGNORED, 16'hFFFF, 10'h3FF);
		send_req(MODE_INSERT, 16'h7FFF, 10'h200);
		repeat (8) send_req(MODE_REMOVE, 16'h0000, 10'h000);
		send_req(MODE_INSERT, 16'h1234, 10'h0F0);
		send_req(MODE_INSERT, 16'h0042, 10'h30F);
		send_req(MODE_CLEAR, 16'hFFFF, 10'h3FF);
		send_req(MODE_REMOVE, 16'h0000, 10'h000);
		send_req(MODE_INSERT, 16'hABCD, 10'h1A5);
		send_req(MODE_REMOVE, 16'h0000, 10'h000);
		drain();

		// mixed traffic around a small heap
		repeat (200) rand_req(55, 2);
		drain();

		// grow the heap to capacity, then work it while full
		while (fill < HEAP_DEPTH)
			rand_req(97, 0);
		repeat (40) rand_req(60, 0);
		repeat (60) rand_req(20, 0);
		send_req(MODE_CLEAR, 16'h0000, 10'h000);
		send_req(MODE_REMOVE, 16'h0000, 10'h000);
		drain();

		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("binary_min_heap_queue_top test passed");
		else
			$display("binary_min_heap_queue_top test failed");
		$finish;
	end

endmodule
